>>> design/dtfb_pkg.sv
`default_nettype none

package dtfb_pkg;

  // Operation carried by each input transaction.
  typedef enum logic [1:0] {
    MODE_WRITE      = 2'd0,
    MODE_READ_COLOR = 2'd1,
    MODE_READ_DEPTH = 2'd2,
    MODE_CLEAR      = 2'd3
  } mode_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_BACKGROUND_RGB = 2'd2;
  localparam logic [1:0] REG_CLEAR_DEPTH    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [8:0]  IMAGE_WIDTH_RST    = 9'd256;
  localparam logic [8:0]  IMAGE_HEIGHT_RST   = 9'd256;
  localparam logic [23:0] BACKGROUND_RGB_RST = 24'h000000;
  localparam logic [23:0] CLEAR_DEPTH_RST    = 24'hFFFFFF;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_RESP
  } state_e;

  // One result item.
  typedef struct packed {
    logic        status;
    logic        was_written;
    logic [23:0] out_depth;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
  } result_t;

endpackage

`default_nettype wire

>>> design/depth_tested_frame_buffer_unit.sv
`default_nettype none

// Depth-tested frame buffer with a colour store and a depth store.
// Input transactions arrive on the s_axis channel; tuser carries the mode
// (write, read colour, read depth, clear) and tdata the coordinates and the
// fragment. Every input transaction produces exactly one result transaction on
// m_axis. Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must do so only while the block is idle, which the block does not enforce.
// A write, read or out-of-range transaction runs through capture and bounds
// check, address multiply, synchronous memory read, then the depth compare
// with write-back. The sequencer takes one item at a time through these steps,
// so a new item is accepted only once the last result is in the output register.
// A clear sweeps both stores one entry per cycle, all MAX_WIDTH * MAX_HEIGHT
// entries, with s_axis_tready low; its result is given after the sweep.
// After reset the same sweep runs to load the background colour 0 and the
// depth 16777215; no result comes from it.
// When the receiver stalls, the result waits in the output register; the next
// item is still accepted and runs until its own result is due, then holds.

module depth_tested_frame_buffer_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: pos_x [15:0], pos_y [31:16], frag_red [39:32], frag_green [47:40],
  //        frag_blue [55:48], frag_depth [79:56]
  input  wire logic [79:0] s_axis_tdata,
  // tuser: mode [1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: out_red [7:0], out_green [15:8], out_blue [23:16], out_depth [47:24],
  //        was_written [48], status [49], zero fill [55:50]
  output logic [55:0]      m_axis_tdata
);

  localparam int StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam int WB        = $clog2(MAX_WIDTH + 1);
  localparam int HB        = $clog2(MAX_HEIGHT + 1);
  localparam int PW        = WB + HB;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreSize - 1);

  // Storage.
  logic [23:0]           col_mem [StoreSize];
  logic [DEPTH_BITS-1:0] dep_mem [StoreSize];

  // Configuration registers.
  logic [8:0]  width_q, height_q;
  logic [23:0] bg_q, cdep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dtfb_pkg::IMAGE_WIDTH_RST;
      height_q <= dtfb_pkg::IMAGE_HEIGHT_RST;
      bg_q     <= dtfb_pkg::BACKGROUND_RGB_RST;
      cdep_q   <= dtfb_pkg::CLEAR_DEPTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtfb_pkg::REG_IMAGE_WIDTH:    width_q  <= cfg_data_i[8:0];
        dtfb_pkg::REG_IMAGE_HEIGHT:   height_q <= cfg_data_i[8:0];
        dtfb_pkg::REG_BACKGROUND_RGB: bg_q     <= cfg_data_i;
        dtfb_pkg::REG_CLEAR_DEPTH:    cdep_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective image size, limited to 1 .. MAX.
  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;

  always_comb begin
    if (width_q == 9'd0) begin
      w_eff = WB'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(width_q);
    end
    if (height_q == 9'd0) begin
      h_eff = HB'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HB'(MAX_HEIGHT);
    end else begin
      h_eff = HB'(height_q);
    end
  end

  // Input field extraction.
  logic [15:0]           in_x, in_y;
  logic [23:0]           in_col;
  logic [DEPTH_BITS-1:0] in_dep;
  dtfb_pkg::mode_e       in_mode;

  assign in_x    = s_axis_tdata[15:0];
  assign in_y    = s_axis_tdata[31:16];
  assign in_col  = {s_axis_tdata[39:32], s_axis_tdata[47:40], s_axis_tdata[55:48]};
  assign in_dep  = DEPTH_BITS'(s_axis_tdata[79:56]);
  assign in_mode = dtfb_pkg::mode_e'(s_axis_tuser);

  // Bounds check and edge clamping at capture.
  logic          x_gt, x_eq, y_gt, y_eq, in_err;
  logic [WB-1:0] xc_d;
  logic [HB-1:0] yc_d;

  always_comb begin
    x_gt   = {1'b0, in_x[14:0]} > 16'(w_eff);
    x_eq   = {1'b0, in_x[14:0]} == 16'(w_eff);
    y_gt   = {1'b0, in_y[14:0]} > 16'(h_eff);
    y_eq   = {1'b0, in_y[14:0]} == 16'(h_eff);
    in_err = in_x[15] || in_y[15] || x_gt || y_gt;
    if (in_err) begin
      xc_d = '0;
    end else if (x_eq) begin
      xc_d = w_eff - WB'(1);
    end else begin
      xc_d = WB'(in_x[14:0]);
    end
    if (in_err) begin
      yc_d = '0;
    end else if (y_eq) begin
      yc_d = h_eff - HB'(1);
    end else begin
      yc_d = HB'(in_y[14:0]);
    end
  end

  // Sequencer and item registers.
  dtfb_pkg::state_e      state_q, state_d;
  logic [AddrW-1:0]      clr_cnt_q;
  logic                  resp_pend_q;
  logic [23:0]           fill_col_q;
  logic [DEPTH_BITS-1:0] fill_dep_q;
  dtfb_pkg::mode_e       mode_q;
  logic                  err_q;
  logic [WB-1:0]         xc_q, w_q;
  logic [HB-1:0]         yc_q, h_q;
  logic [23:0]           col_q;
  logic [DEPTH_BITS-1:0] fdep_q;
  logic [AddrW-1:0]      idx_q;
  logic                  m_valid_q;
  dtfb_pkg::result_t     res_q, res_d;

  logic s_fire, out_free, sweep_last;
  assign s_axis_tready = (state_q == dtfb_pkg::ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign sweep_last    = (clr_cnt_q == LastAddr);

  // Memory read data.
  logic [23:0]           rd_col_q;
  logic [DEPTH_BITS-1:0] rd_dep_q;
  logic                  pass;
  assign pass = (fdep_q < rd_dep_q);

  // Next state and result.
  always_comb begin
    state_d = state_q;
    res_d   = '0;
    unique case (state_q)
      dtfb_pkg::ST_CLEAR: begin
        if (sweep_last) begin
          state_d = resp_pend_q ? dtfb_pkg::ST_RESP : dtfb_pkg::ST_IDLE;
        end
      end
      dtfb_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_d = (in_mode == dtfb_pkg::MODE_CLEAR) ? dtfb_pkg::ST_CLEAR
                                                       : dtfb_pkg::ST_CALC;
        end
      end
      dtfb_pkg::ST_CALC: state_d = dtfb_pkg::ST_READ;
      dtfb_pkg::ST_READ: state_d = dtfb_pkg::ST_RESP;
      dtfb_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = dtfb_pkg::ST_IDLE;
        end
      end
      default: state_d = dtfb_pkg::ST_IDLE;
    endcase

    // Result fields for the item in flight.
    if (err_q && mode_q != dtfb_pkg::MODE_CLEAR) begin
      res_d.status = 1'b1;
    end else begin
      case (mode_q)
        dtfb_pkg::MODE_WRITE:      res_d.was_written = pass;
        dtfb_pkg::MODE_READ_COLOR: begin
          res_d.out_red   = rd_col_q[23:16];
          res_d.out_green = rd_col_q[15:8];
          res_d.out_blue  = rd_col_q[7:0];
        end
        dtfb_pkg::MODE_READ_DEPTH: res_d.out_depth = 24'(rd_dep_q);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtfb_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      resp_pend_q <= 1'b0;
      fill_col_q  <= dtfb_pkg::BACKGROUND_RGB_RST;
      fill_dep_q  <= DEPTH_BITS'(dtfb_pkg::CLEAR_DEPTH_RST);
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // Sweep address runs only while clearing.
      if (state_q == dtfb_pkg::ST_CLEAR) begin
        clr_cnt_q <= sweep_last ? '0 : clr_cnt_q + AddrW'(1);
      end
      // A clear transaction latches its fill values and owes a result.
      if (s_fire) begin
        resp_pend_q <= (in_mode == dtfb_pkg::MODE_CLEAR);
        if (in_mode == dtfb_pkg::MODE_CLEAR) begin
          fill_col_q <= bg_q;
          fill_dep_q <= DEPTH_BITS'(cdep_q);
        end
      end
      // Output register handshake.
      if (state_q == dtfb_pkg::ST_RESP && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Item payload capture and address computation.
  logic [PW-1:0] row_prod;
  logic [HB-1:0] row;
  assign row      = h_q - HB'(1) - yc_q;
  assign row_prod = PW'(row) * PW'(w_q);

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      mode_q <= in_mode;
      err_q  <= in_err;
      xc_q   <= xc_d;
      yc_q   <= yc_d;
      w_q    <= w_eff;
      h_q    <= h_eff;
      col_q  <= in_col;
      fdep_q <= in_dep;
    end
    if (state_q == dtfb_pkg::ST_CALC) begin
      idx_q <= AddrW'(row_prod + PW'(xc_q));
    end
    if (state_q == dtfb_pkg::ST_RESP && out_free) begin
      res_q <= res_d;
    end
  end

  // Memory write port: clearing sweep or a passing depth-tested write.
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  logic [23:0]           wr_col;
  logic [DEPTH_BITS-1:0] wr_dep;

  always_comb begin
    if (state_q == dtfb_pkg::ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_col  = fill_col_q;
      wr_dep  = fill_dep_q;
    end else begin
      wr_en   = (state_q == dtfb_pkg::ST_RESP) && out_free && !err_q &&
                (mode_q == dtfb_pkg::MODE_WRITE) && pass;
      wr_addr = idx_q;
      wr_col  = col_q;
      wr_dep  = fdep_q;
    end
  end

  // Colour and depth stores.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      col_mem[wr_addr] <= wr_col;
      dep_mem[wr_addr] <= wr_dep;
    end
    if (state_q == dtfb_pkg::ST_READ) begin
      rd_col_q <= col_mem[idx_q];
      rd_dep_q <= dep_mem[idx_q];
    end
  end

  // Output packing.
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, res_q};

endmodule

`default_nettype wire

>>> sim/tb_depth_tested_frame_buffer_unit.sv
`timescale 1ns / 100ps

module tb_depth_tested_frame_buffer_unit;

  localparam int MAX_W       = 256;
  localparam int MAX_H       = 256;
  localparam int STORE_WORDS = MAX_W * MAX_H;
  // A clear or the reset sweep runs with nothing accepted.
  localparam int STALL_LIMIT = 262144;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 105;

  // One fragment or command on the input stream.
  typedef struct {
    dtfb_pkg::mode_e    mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [23:0]        depth;
  } fragment_t;

  // Keeps its own copy of both stores and the registers, and the results owed.
  class pixel_scoreboard;
    bit [23:0]  color_mem [STORE_WORDS];
    bit [23:0]  depth_mem [STORE_WORDS];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [23:0] bg_reg;
    logic [23:0] zclear_reg;
    dtfb_pkg::result_t frame_results_q [$];
    int          errors;

    function new();
      width_reg  = dtfb_pkg::IMAGE_WIDTH_RST;
      height_reg = dtfb_pkg::IMAGE_HEIGHT_RST;
      bg_reg     = dtfb_pkg::BACKGROUND_RGB_RST;
      zclear_reg = dtfb_pkg::CLEAR_DEPTH_RST;
      errors     = 0;
      fill_store();
    endfunction

    function void fill_store();
      for (int i = 0; i < STORE_WORDS; i++) begin
        color_mem[i] = bg_reg;
        depth_mem[i] = zclear_reg;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        dtfb_pkg::REG_IMAGE_WIDTH:    width_reg  = val[8:0];
        dtfb_pkg::REG_IMAGE_HEIGHT:   height_reg = val[8:0];
        dtfb_pkg::REG_BACKGROUND_RGB: bg_reg     = val;
        dtfb_pkg::REG_CLEAR_DEPTH:    zclear_reg = val;
        default: ;
      endcase
    endfunction

    // Size registers outside 1..max are taken at the nearest end.
    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return int'(width_reg);
    endfunction

    function int eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return int'(height_reg);
    endfunction

    // Works out the result of one accepted transaction and updates the stores.
    function void apply_fragment(fragment_t f);
      dtfb_pkg::result_t r;
      int x, y, w, h, addr;
      r = '0;
      x = f.pos_x;
      y = f.pos_y;
      w = eff_width();
      h = eff_height();
      if (f.mode == dtfb_pkg::MODE_CLEAR) begin
        fill_store();
      end else if (x < 0 || y < 0 || x > w || y > h) begin
        r.status = 1'b1;
      end else begin
        // A coordinate on the far edge lands on the last pixel.
        if (x == w) x = w - 1;
        if (y == h) y = h - 1;
        // Rows are stored top to bottom.
        addr = x + (h - 1 - y) * w;
        case (f.mode)
          dtfb_pkg::MODE_WRITE: begin
            if (f.depth < depth_mem[addr]) begin
              color_mem[addr] = {f.red, f.green, f.blue};
              depth_mem[addr] = f.depth;
              r.was_written   = 1'b1;
            end
          end
          dtfb_pkg::MODE_READ_COLOR: begin
            {r.out_red, r.out_green, r.out_blue} = color_mem[addr];
          end
          default: r.out_depth = depth_mem[addr];
        endcase
      end
      frame_results_q.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void compare_result(logic [55:0] data);
      dtfb_pkg::result_t got, want;
      got = data[49:0];
      if (frame_results_q.size() == 0) begin
        $error("result transaction with no expectation, tdata %h", data);
        errors++;
        return;
      end
      want = frame_results_q.pop_front();
      check_field("out_red", want.out_red, got.out_red);
      check_field("out_green", want.out_green, got.out_green);
      check_field("out_blue", want.out_blue, got.out_blue);
      check_field("out_depth", want.out_depth, got.out_depth);
      check_field("was_written", want.was_written, got.was_written);
      check_field("status", want.status, got.status);
      check_field("zero_fill", 0, data[55:50]);
    endfunction

    function int pending();
      return frame_results_q.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [23:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  pixel_scoreboard sb;
  bit              no_idle = 1'b0;
  int              stall_cycles = 0;
  int              clears_left = 2;
  int              recent_x [$];
  int              recent_y [$];

  depth_tested_frame_buffer_unit dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #4 clk_i = ~clk_i;

  // Receiver stalls at random except during the quiet stretch.
  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 30);
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.compare_result(m_axis_tdata);
  end

  // Ends the run when nothing moves on either stream for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_depth_tested_frame_buffer_unit failed");
      $finish;
    end
  end

  // Offers one transaction, with random gaps, and records it once accepted.
  // Starts and returns at a falling edge with tvalid still high.
  task automatic send_fragment(fragment_t f);
    while (!no_idle && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f.mode;
    s_axis_tdata  <= {f.depth, f.blue, f.green, f.red, f.pos_y, f.pos_x};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_fragment(f);
    @(negedge clk_i);
  endtask

  task automatic send_op(dtfb_pkg::mode_e m, int x, int y, logic [7:0] r,
                         logic [7:0] g, logic [7:0] b, logic [23:0] d);
    fragment_t f;
    f.mode  = m;
    f.pos_x = 16'(x);
    f.pos_y = 16'(y);
    f.red   = r;
    f.green = g;
    f.blue  = b;
    f.depth = d;
    send_fragment(f);
  endtask

  // Holds the sender back until every owed result has arrived.
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic configure(logic [8:0] w, logic [8:0] h, logic [23:0] bg, logic [23:0] zc);
    logic [23:0] vals [4];
    vals[dtfb_pkg::REG_IMAGE_WIDTH]    = {15'd0, w};
    vals[dtfb_pkg::REG_IMAGE_HEIGHT]   = {15'd0, h};
    vals[dtfb_pkg::REG_BACKGROUND_RGB] = bg;
    vals[dtfb_pkg::REG_CLEAR_DEPTH]    = zc;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(2'(i), vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mostly inside the image, sometimes on the clamped edge or outside it.
  function automatic int pick_coord(int lim);
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(0, lim - 1);
    if (p < 88) return lim;
    if (p < 91) return lim + 1;
    if (p < 95) return -int'($urandom_range(1, 3));
    return int'($signed(16'($urandom)));
  endfunction

  function automatic fragment_t random_fragment();
    fragment_t f;
    int x, y, p, k;
    p = $urandom_range(0, 99);
    if (clears_left > 0 && $urandom_range(0, 149) == 0) begin
      f.mode = dtfb_pkg::MODE_CLEAR;
      clears_left--;
    end else if (p < 45) begin
      f.mode = dtfb_pkg::MODE_WRITE;
    end else if (p < 72) begin
      f.mode = dtfb_pkg::MODE_READ_COLOR;
    end else begin
      f.mode = dtfb_pkg::MODE_READ_DEPTH;
    end
    // Revisit recently written pixels so reads and depth tests see real data.
    if ($urandom_range(0, 99) < 40 && recent_x.size() > 0) begin
      k = $urandom_range(0, recent_x.size() - 1);
      x = recent_x[k];
      y = recent_y[k];
    end else begin
      x = pick_coord(sb.eff_width());
      y = pick_coord(sb.eff_height());
    end
    if (f.mode == dtfb_pkg::MODE_WRITE && x >= 0 && y >= 0 &&
        x <= sb.eff_width() && y <= sb.eff_height()) begin
      recent_x.push_back(x);
      recent_y.push_back(y);
      if (recent_x.size() > 8) begin
        void'(recent_x.pop_front());
        void'(recent_y.pop_front());
      end
    end
    f.pos_x = 16'(x);
    f.pos_y = 16'(y);
    f.red   = 8'($urandom);
    f.green = 8'($urandom);
    f.blue  = 8'($urandom);
    p = $urandom_range(0, 99);
    if (p < 8) f.depth = 24'h000000;
    else if (p < 16) f.depth = 24'hFFFFFF;
    else f.depth = 24'($urandom);
    return f;
  endfunction

  initial begin
    logic [8:0]  ph_w  [PHASES];
    logic [8:0]  ph_h  [PHASES];
    logic [23:0] ph_bg [PHASES];
    logic [23:0] ph_zc [PHASES];

    sb = new();
    // Register settings per phase, from the smallest image to out-of-range sizes.
    ph_w[0] = 9'd1;   ph_h[0] = 9'd1;   ph_bg[0] = 24'hFFFFFF;       ph_zc[0] = 24'h000000;
    ph_w[1] = 9'd4;   ph_h[1] = 9'd3;   ph_bg[1] = 24'($urandom);    ph_zc[1] = 24'($urandom);
    ph_w[2] = 9'd0;   ph_h[2] = 9'd511; ph_bg[2] = 24'($urandom);    ph_zc[2] = 24'hFFFFFF;
    ph_w[3] = 9'd16;  ph_h[3] = 9'd9;   ph_bg[3] = 24'($urandom);    ph_zc[3] = 24'hFFFFFF;
    ph_w[4] = 9'd300; ph_h[4] = 9'd256; ph_bg[4] = 24'h000000;       ph_zc[4] = 24'hFFFFFF;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    // The block sweeps both stores after reset before it takes anything.
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);

    // Directed part at the reset sizes of 256 by 256.
    send_op(dtfb_pkg::MODE_READ_COLOR, 0, 0, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_READ_DEPTH, 0, 0, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_WRITE, 0, 0, 8'hFF, 8'hFF, 8'hFF, 24'h000000);
    // An equal depth does not pass the test.
    send_op(dtfb_pkg::MODE_WRITE, 0, 0, 8'h12, 8'h34, 8'h56, 24'h000000);
    send_op(dtfb_pkg::MODE_READ_COLOR, 0, 0, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_READ_DEPTH, 0, 0, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_WRITE, 255, 255, 8'hAA, 8'h55, 8'hAA, 24'hFFFFFF);
    send_op(dtfb_pkg::MODE_WRITE, 255, 255, 8'h00, 8'h00, 8'h00, 24'hFFFFFE);
    // Coordinates equal to the size clamp to the last pixel.
    send_op(dtfb_pkg::MODE_WRITE, 256, 255, 8'h5A, 8'hA5, 8'h0F, 24'h000005);
    send_op(dtfb_pkg::MODE_READ_COLOR, 256, 256, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_READ_DEPTH, 255, 256, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_READ_DEPTH, 0, 255, 8'h00, 8'h00, 8'h00, 24'h000000);
    // Out-of-bounds coordinates report an error and leave the stores alone.
    send_op(dtfb_pkg::MODE_WRITE, -1, 0, 8'hFF, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_READ_COLOR, 0, -1, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_READ_DEPTH, 257, 0, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_WRITE, 0, 257, 8'h00, 8'hFF, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_READ_COLOR, -32768, 32767, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_WRITE, 32767, -32768, 8'hFF, 8'hFF, 8'hFF, 24'h000000);
    send_op(dtfb_pkg::MODE_READ_COLOR, 255, 255, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_CLEAR, 0, 0, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_READ_COLOR, 255, 255, 8'h00, 8'h00, 8'h00, 24'h000000);
    send_op(dtfb_pkg::MODE_READ_DEPTH, 0, 0, 8'h00, 8'h00, 8'h00, 24'h000000);

    // Random phases, each starting from a clear under new register settings.
    for (int p = 0; p < PHASES; p++) begin
      hold_until_drained();
      repeat (8) @(negedge clk_i);
      configure(ph_w[p], ph_h[p], ph_bg[p], ph_zc[p]);
      recent_x.delete();
      recent_y.delete();
      no_idle = (p == 2);
      send_op(dtfb_pkg::MODE_CLEAR, 0, 0, 8'h00, 8'h00, 8'h00, 24'h000000);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 49) hold_until_drained();
        send_fragment(random_fragment());
      end
    end
    no_idle = 1'b0;

    // Let every owed result arrive, then keep watching for stray ones.
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_depth_tested_frame_buffer_unit passed");
    end else begin
      $display("tb_depth_tested_frame_buffer_unit failed");
    end
    $finish;
  end

endmodule
